/* src/dram_same_bank_refresh_manager_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the same-bank refresh manager
// Clocked concurrent assertions, with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef DRAM_SAME_BANK_REFRESH_MANAGER_TOP_MACROS_SVH
`define DRAM_SAME_BANK_REFRESH_MANAGER_TOP_MACROS_SVH

// check only while out of reset
`define DSBRM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check on every edge, reset included
`define DSBRM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/dsbrm_pkg.sv */
// ----------------------------------------------------------------------------
// Same-bank refresh manager package
// Field widths, reset values, command and register codes, and beat types shared by the RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsbrm_pkg;

    localparam int TIME_W      = 48;
    localparam int MASK_W      = 32;
    localparam int FLEX_W      = 8;
    localparam int INTERVAL_W  = 16;
    localparam int LIMIT_W     = 7;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [TIME_W-1:0]     TRIGGER_RESET  = 48'd1950;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1950;
    localparam logic [LIMIT_W-1:0]    POSTPONE_RESET = 7'd32;
    localparam logic [LIMIT_W-1:0]    PULLIN_RESET   = 7'd32;

    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;

    localparam logic [1:0] CMD_NOP   = 2'd0;
    localparam logic [1:0] CMD_REFSB = 2'd1;
    localparam logic [1:0] CMD_PRESB = 2'd2;
    localparam logic [1:0] CMD_RFMSB = 2'd3;

    localparam logic [2:0] ISSUE_REFSB = 3'd0;
    localparam logic [2:0] ISSUE_REFAB = 3'd1;
    localparam logic [2:0] ISSUE_PDE   = 3'd2;
    localparam logic [2:0] ISSUE_SRE   = 3'd3;
    localparam logic [2:0] ISSUE_PDX   = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_REFRESH_INTERVAL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_TRIGGER    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_POSTPONED    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PULLED_IN    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RFM_ENABLE       = 3'd4;

    typedef struct packed {
        logic                  func;
        logic [TIME_W-1:0]     now;
        logic [2:0]            issued_command;
        logic [MASK_W-1:0]     idle_mask;
        logic [MASK_W-1:0]     activated_mask;
        logic [MASK_W-1:0]     mmt_mask;
        logic [MASK_W-1:0]     imt_mask;
    } item_t;

    typedef struct packed {
        logic [1:0]        next_command;
        logic [1:0]        target_set;
        logic              block_request;
        logic              pdm_interrupt;
        logic [TIME_W-1:0] next_trigger;
    } result_t;

    typedef struct packed {
        logic                   wr_en;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_write_t;

endpackage

/* src/dsbrm_engine.sv */
// ----------------------------------------------------------------------------
// Same-bank refresh decision engine
// Holds configuration and scheduler state; decides one beat per cycle while advance is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsbrm_engine #(
    parameter int BANKS_PER_GROUP = 4,
    parameter int GROUPS_PER_RANK = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dsbrm_pkg::cfg_write_t cfg,
    input  dsbrm_pkg::item_t     item,
    input  logic                 advance,
    output dsbrm_pkg::result_t   result
);

    localparam int SET_W = (BANKS_PER_GROUP > 1) ? $clog2(BANKS_PER_GROUP) : 1;
    localparam int TW    = dsbrm_pkg::TIME_W;
    localparam logic [BANKS_PER_GROUP-1:0] ALL_SETS = {BANKS_PER_GROUP{1'b1}};
    localparam logic [BANKS_PER_GROUP-1:0] ONE_SET  = BANKS_PER_GROUP'(1);

    logic [dsbrm_pkg::INTERVAL_W-1:0] refresh_interval_reg;
    logic [dsbrm_pkg::LIMIT_W-1:0]    max_postponed_reg;
    logic [dsbrm_pkg::LIMIT_W-1:0]    max_pulled_in_reg;
    logic                             rfm_enable_reg;

    logic [TW-1:0]                trigger_time_reg,   trigger_time_next;
    logic                         pulled_in_mode_reg, pulled_in_mode_next;
    logic [dsbrm_pkg::FLEX_W-1:0] flex_count_reg,     flex_count_next;
    logic [BANKS_PER_GROUP-1:0]   remaining_sets_reg, remaining_sets_next;
    logic [SET_W-1:0]             current_set_reg,    current_set_next;
    logic                         skip_select_reg,    skip_select_next;
    logic                         asleep_reg,         asleep_next;

    logic [BANKS_PER_GROUP-1:0][GROUPS_PER_RANK-1:0] idle_m, act_m, mmt_m, imt_m;
    logic [BANKS_PER_GROUP-1:0] all_idle, any_act, any_mmt, any_imt;
    logic [BANKS_PER_GROUP-1:0] idle_rem, imt_cand, rem_clr, rem_new;

    logic [TW:0]   sum1, sum2, now_sum;
    logic [TW-1:0] sat1, sat2, sat_now;
    logic          at_trigger, catch_up, forced, pull_limit, busy, rfm_go;
    logic [1:0]    cmd;
    logic          blk, irq;
    logic [SET_W-1:0] low_rem, pick_set, hi_mmt, lo_imt, low_new;

    function automatic logic [SET_W-1:0] lowest_idx(input logic [BANKS_PER_GROUP-1:0] m);
        logic [SET_W-1:0] r;
        r = '0;
        for (int s = BANKS_PER_GROUP - 1; s >= 0; s--) begin
            if (m[s]) r = SET_W'(s);
        end
        return r;
    endfunction

    function automatic logic [SET_W-1:0] highest_idx(input logic [BANKS_PER_GROUP-1:0] m);
        logic [SET_W-1:0] r;
        r = '0;
        for (int s = 0; s < BANKS_PER_GROUP; s++) begin
            if (m[s]) r = SET_W'(s);
        end
        return r;
    endfunction

    for (genvar s = 0; s < BANKS_PER_GROUP; s++) begin : g_set
        for (genvar g = 0; g < GROUPS_PER_RANK; g++) begin : g_grp
            localparam int B = g * BANKS_PER_GROUP + s;
            if (B < dsbrm_pkg::MASK_W) begin : g_in
                assign idle_m[s][g] = item.idle_mask[B];
                assign act_m[s][g]  = item.activated_mask[B];
                assign mmt_m[s][g]  = item.mmt_mask[B];
                assign imt_m[s][g]  = item.imt_mask[B];
            end else begin : g_out
                assign idle_m[s][g] = 1'b0;
                assign act_m[s][g]  = 1'b0;
                assign mmt_m[s][g]  = 1'b0;
                assign imt_m[s][g]  = 1'b0;
            end
        end
        assign all_idle[s] = &idle_m[s];
        assign any_act[s]  = |act_m[s];
        assign any_mmt[s]  = |mmt_m[s];
        assign any_imt[s]  = |imt_m[s];
    end

    assign sum1    = {1'b0, trigger_time_reg} + (TW+1)'(refresh_interval_reg);
    assign sum2    = {1'b0, trigger_time_reg} + (TW+1)'({refresh_interval_reg, 1'b0});
    assign now_sum = {1'b0, item.now} + (TW+1)'(refresh_interval_reg);
    assign sat1    = sum1[TW]    ? dsbrm_pkg::TIME_MAX : sum1[TW-1:0];
    assign sat2    = sum2[TW]    ? dsbrm_pkg::TIME_MAX : sum2[TW-1:0];
    assign sat_now = now_sum[TW] ? dsbrm_pkg::TIME_MAX : now_sum[TW-1:0];

    assign at_trigger = item.now >= trigger_time_reg;
    assign catch_up   = {1'b0, item.now} >= sum1;
    assign forced     = {flex_count_reg[7], flex_count_reg} == {2'b00, max_postponed_reg};

    assign idle_rem = remaining_sets_reg & all_idle;
    assign imt_cand = any_imt & all_idle;
    assign low_rem  = lowest_idx(remaining_sets_reg);
    assign pick_set = lowest_idx(idle_rem);
    assign hi_mmt   = highest_idx(any_mmt);
    assign lo_imt   = lowest_idx(imt_cand);

    assign rem_clr  = remaining_sets_reg & ~(ONE_SET << current_set_reg);
    assign rem_new  = (rem_clr == '0) ? ALL_SETS : rem_clr;
    assign low_new  = lowest_idx(rem_new);

    always_comb begin
        trigger_time_next   = trigger_time_reg;
        pulled_in_mode_next = pulled_in_mode_reg;
        flex_count_next     = flex_count_reg;
        remaining_sets_next = remaining_sets_reg;
        current_set_next    = current_set_reg;
        skip_select_next    = skip_select_reg;
        asleep_next         = asleep_reg;
        cmd        = dsbrm_pkg::CMD_NOP;
        blk        = 1'b0;
        irq        = 1'b0;
        rfm_go     = 1'b1;
        busy       = 1'b1;
        pull_limit = 1'b0;

        if (item.func == dsbrm_pkg::FUNC_TICK) begin
            if (at_trigger) begin
                irq = 1'b1;
                if (asleep_reg) begin
                    rfm_go = 1'b0;
                end else if (catch_up || !pulled_in_mode_reg) begin
                    pulled_in_mode_next = 1'b0;
                    if (catch_up) trigger_time_next = sat1;
                    if (!skip_select_reg) begin
                        busy = (idle_rem == '0);
                        current_set_next = busy ? low_rem : pick_set;
                    end
                    if (busy && !forced) begin
                        if (flex_count_reg != 8'h7F) flex_count_next = flex_count_reg + 8'd1;
                        trigger_time_next = catch_up ? sat2 : sat1;
                    end else begin
                        rfm_go = 1'b0;
                        cmd = any_act[current_set_next] ? dsbrm_pkg::CMD_PRESB
                                                        : dsbrm_pkg::CMD_REFSB;
                        if (cmd == dsbrm_pkg::CMD_REFSB && forced) begin
                            blk = 1'b1;
                            skip_select_next = 1'b1;
                        end
                    end
                end else begin
                    busy = (idle_rem == '0);
                    current_set_next = busy ? low_rem : pick_set;
                    if (busy) begin
                        pulled_in_mode_next = 1'b0;
                        trigger_time_next   = sat1;
                    end else begin
                        rfm_go = 1'b0;
                        cmd = any_act[current_set_next] ? dsbrm_pkg::CMD_PRESB
                                                        : dsbrm_pkg::CMD_REFSB;
                    end
                end
            end
            if (rfm_go && rfm_enable_reg) begin
                if (any_mmt != '0) begin
                    current_set_next = hi_mmt;
                    blk = 1'b1;
                    cmd = any_act[hi_mmt] ? dsbrm_pkg::CMD_PRESB : dsbrm_pkg::CMD_RFMSB;
                end else if (imt_cand != '0) begin
                    current_set_next = lo_imt;
                    cmd = any_act[lo_imt] ? dsbrm_pkg::CMD_PRESB : dsbrm_pkg::CMD_RFMSB;
                end
            end
        end else begin
            case (item.issued_command)
                dsbrm_pkg::ISSUE_REFSB: begin
                    skip_select_next    = 1'b0;
                    remaining_sets_next = rem_new;
                    current_set_next    = low_new;
                    pulled_in_mode_next = 1'b1;
                    if (pulled_in_mode_reg && flex_count_reg != 8'h80) begin
                        flex_count_next = flex_count_reg - 8'd1;
                    end
                    pull_limit = {flex_count_next[7], flex_count_next}
                                 == (9'd0 - {2'b00, max_pulled_in_reg});
                    if (pull_limit) begin
                        pulled_in_mode_next = 1'b0;
                        trigger_time_next   = sat1;
                    end
                end
                dsbrm_pkg::ISSUE_REFAB: begin
                    pulled_in_mode_next = 1'b0;
                    trigger_time_next   = sat_now;
                    asleep_next         = 1'b0;
                    remaining_sets_next = ALL_SETS;
                    current_set_next    = '0;
                    skip_select_next    = 1'b0;
                end
                dsbrm_pkg::ISSUE_PDE: begin
                    asleep_next = 1'b1;
                end
                dsbrm_pkg::ISSUE_SRE: begin
                    asleep_next       = 1'b1;
                    trigger_time_next = dsbrm_pkg::TIME_MAX;
                end
                dsbrm_pkg::ISSUE_PDX: begin
                    asleep_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign result.next_command  = cmd;
    assign result.target_set    = 2'(current_set_next);
    assign result.block_request = blk;
    assign result.pdm_interrupt = irq;
    assign result.next_trigger  = trigger_time_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            refresh_interval_reg <= dsbrm_pkg::INTERVAL_RESET;
            max_postponed_reg    <= dsbrm_pkg::POSTPONE_RESET;
            max_pulled_in_reg    <= dsbrm_pkg::PULLIN_RESET;
            rfm_enable_reg       <= 1'b0;
            trigger_time_reg     <= dsbrm_pkg::TRIGGER_RESET;
            pulled_in_mode_reg   <= 1'b0;
            flex_count_reg       <= '0;
            remaining_sets_reg   <= ALL_SETS;
            current_set_reg      <= '0;
            skip_select_reg      <= 1'b0;
            asleep_reg           <= 1'b0;
        end else begin
            if (cfg.wr_en && cfg.index == dsbrm_pkg::CFG_FIRST_TRIGGER) begin
                trigger_time_reg <= TW'(cfg.data);
            end else if (advance) begin
                trigger_time_reg <= trigger_time_next;
            end
            if (advance) begin
                pulled_in_mode_reg <= pulled_in_mode_next;
                flex_count_reg     <= flex_count_next;
                remaining_sets_reg <= remaining_sets_next;
                current_set_reg    <= current_set_next;
                skip_select_reg    <= skip_select_next;
                asleep_reg         <= asleep_next;
            end
            if (cfg.wr_en) begin
                case (cfg.index)
                    dsbrm_pkg::CFG_REFRESH_INTERVAL: begin
                        refresh_interval_reg <= cfg.data[dsbrm_pkg::INTERVAL_W-1:0];
                    end
                    dsbrm_pkg::CFG_MAX_POSTPONED: begin
                        max_postponed_reg <= cfg.data[dsbrm_pkg::LIMIT_W-1:0];
                    end
                    dsbrm_pkg::CFG_MAX_PULLED_IN: begin
                        max_pulled_in_reg <= cfg.data[dsbrm_pkg::LIMIT_W-1:0];
                    end
                    dsbrm_pkg::CFG_RFM_ENABLE: begin
                        rfm_enable_reg <= cfg.data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

/* src/dram_same_bank_refresh_manager_top.sv */
// ----------------------------------------------------------------------------
// Same-bank refresh manager, top level
// Input beat register, decision engine and result register for one rank.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | func, now, issued_command, four bank masks
//  m_      | out | m_valid / m_ready  | next_command, target_set, block_request,
//          |     |                    | pdm_interrupt, next_trigger
//  cfg_    | in  | cfg_wr_en          | cfg_index, cfg_data
//
//  One beat per cycle sustained while m_ready stays high; a result passes the
//  input register, then the result register, before it shows on m_, and is
//  set by the one-pass decision.
//  Scheduler state updates when a beat moves from the input register to the
//  result register, so the next beat always sees it.
//  A stalled m_ side holds the result register; the input register still takes
//  one more beat, then s_ready drops until the result is taken.
//  Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dram_same_bank_refresh_manager_top #(
    parameter int BANKS_PER_GROUP = 4,
    parameter int GROUPS_PER_RANK = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [dsbrm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dsbrm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic [dsbrm_pkg::TIME_W-1:0]      s_now,
    input  logic [2:0]                        s_issued_command,
    input  logic [dsbrm_pkg::MASK_W-1:0]      s_idle_mask,
    input  logic [dsbrm_pkg::MASK_W-1:0]      s_activated_mask,
    input  logic [dsbrm_pkg::MASK_W-1:0]      s_mmt_mask,
    input  logic [dsbrm_pkg::MASK_W-1:0]      s_imt_mask,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_next_command,
    output logic [1:0]                        m_target_set,
    output logic                              m_block_request,
    output logic                              m_pdm_interrupt,
    output logic [dsbrm_pkg::TIME_W-1:0]      m_next_trigger
);

    logic                 stage_valid_reg;
    dsbrm_pkg::item_t     stage_item_reg;
    logic                 m_valid_reg;
    dsbrm_pkg::result_t   m_beat_reg;
    dsbrm_pkg::result_t   result;
    dsbrm_pkg::cfg_write_t cfg;
    logic                 advance;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign advance = stage_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !stage_valid_reg || advance;

    dsbrm_engine #(
        .BANKS_PER_GROUP(BANKS_PER_GROUP),
        .GROUPS_PER_RANK(GROUPS_PER_RANK)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (stage_item_reg),
        .advance (advance),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (s_ready) begin
                stage_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            stage_item_reg.func           <= s_func;
            stage_item_reg.now            <= s_now;
            stage_item_reg.issued_command <= s_issued_command;
            stage_item_reg.idle_mask      <= s_idle_mask;
            stage_item_reg.activated_mask <= s_activated_mask;
            stage_item_reg.mmt_mask       <= s_mmt_mask;
            stage_item_reg.imt_mask       <= s_imt_mask;
        end
        if (advance) begin
            m_beat_reg <= result;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_next_command  = m_beat_reg.next_command;
    assign m_target_set    = m_beat_reg.target_set;
    assign m_block_request = m_beat_reg.block_request;
    assign m_pdm_interrupt = m_beat_reg.pdm_interrupt;
    assign m_next_trigger  = m_beat_reg.next_trigger;

endmodule

/* src/dsbrm_checker.sv */
// ----------------------------------------------------------------------------
// Same-bank refresh manager port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dram_same_bank_refresh_manager_top_macros.svh"

module dsbrm_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [1:0]                   m_next_command,
    input logic [1:0]                   m_target_set,
    input logic                         m_block_request,
    input logic [dsbrm_pkg::TIME_W-1:0] m_next_trigger
);

    // hold a stalled result beat
    `DSBRM_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_next_command) && $stable(m_target_set) && $stable(m_next_trigger), "stalled result beat changed")

    // block only with a real command
    `DSBRM_ASSERT(a_nop_no_block, aclk, aresetn, m_valid && m_next_command == dsbrm_pkg::CMD_NOP |-> !m_block_request, "block request on a NOP beat")

    // drop input ready only behind a stalled result
    `DSBRM_ASSERT(a_ready_backpressure, aclk, aresetn, !s_ready |-> m_valid && !m_ready, "input stalled without output backpressure")

    // no result right after reset
    `DSBRM_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind dram_same_bank_refresh_manager_top dsbrm_checker u_dsbrm_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_next_command  (m_next_command),
    .m_target_set    (m_target_set),
    .m_block_request (m_block_request),
    .m_next_trigger  (m_next_trigger)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Same-bank refresh manager testbench
// Drives evaluate ticks and command reports into the block with random source
// gaps and sink stalls, predicts each result from a behavioral copy of the
// scheduler state, and compares every result beat field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int BANKS_PER_GROUP = 4;
    localparam int GROUPS_PER_RANK = 8;
    localparam logic [BANKS_PER_GROUP-1:0] ALL_SETS = '1;
    localparam logic [31:0] SET0_BANKS = 32'h1111_1111;

    logic                              aclk             = 1'b0;
    logic                              aresetn          = 1'b0;
    logic                              cfg_wr_en        = 1'b0;
    logic [dsbrm_pkg::CFG_INDEX_W-1:0] cfg_index        = '0;
    logic [dsbrm_pkg::CFG_DATA_W-1:0]  cfg_data         = '0;
    logic                              s_valid          = 1'b0;
    logic                              s_ready;
    logic                              s_func           = 1'b0;
    logic [dsbrm_pkg::TIME_W-1:0]      s_now            = '0;
    logic [2:0]                        s_issued_command = '0;
    logic [dsbrm_pkg::MASK_W-1:0]      s_idle_mask      = '0;
    logic [dsbrm_pkg::MASK_W-1:0]      s_activated_mask = '0;
    logic [dsbrm_pkg::MASK_W-1:0]      s_mmt_mask       = '0;
    logic [dsbrm_pkg::MASK_W-1:0]      s_imt_mask       = '0;
    logic                              m_valid;
    logic                              m_ready          = 1'b0;
    logic [1:0]                        m_next_command;
    logic [1:0]                        m_target_set;
    logic                              m_block_request;
    logic                              m_pdm_interrupt;
    logic [dsbrm_pkg::TIME_W-1:0]      m_next_trigger;

    dram_same_bank_refresh_manager_top #(
        .BANKS_PER_GROUP(BANKS_PER_GROUP),
        .GROUPS_PER_RANK(GROUPS_PER_RANK)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_now           (s_now),
        .s_issued_command(s_issued_command),
        .s_idle_mask     (s_idle_mask),
        .s_activated_mask(s_activated_mask),
        .s_mmt_mask      (s_mmt_mask),
        .s_imt_mask      (s_imt_mask),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_next_command  (m_next_command),
        .m_target_set    (m_target_set),
        .m_block_request (m_block_request),
        .m_pdm_interrupt (m_pdm_interrupt),
        .m_next_trigger  (m_next_trigger)
    );

    // scheduler copy
    logic [dsbrm_pkg::INTERVAL_W-1:0] cfg_interval = dsbrm_pkg::INTERVAL_RESET;
    int                         cfg_max_post = int'(dsbrm_pkg::POSTPONE_RESET);
    int                         cfg_max_pull = int'(dsbrm_pkg::PULLIN_RESET);
    bit                         cfg_rfm      = 1'b0;
    logic [dsbrm_pkg::TIME_W-1:0] trig_time  = dsbrm_pkg::TRIGGER_RESET;
    bit                         pulled_in    = 1'b0;
    int                         flex         = 0;
    logic [BANKS_PER_GROUP-1:0] remaining    = ALL_SETS;
    int                         cur_set      = 0;
    bit                         skip_sel     = 1'b0;
    bit                         sleeping     = 1'b0;

    dsbrm_pkg::item_t   pending_items[$];
    dsbrm_pkg::result_t expected_results[$];

    int                           send_idle_pct  = 0;
    int                           recv_stall_pct = 0;
    int                           mismatches     = 0;
    logic [15:0]                  phase_interval = 16'd1;
    logic [dsbrm_pkg::TIME_W-1:0] base_now       = '0;

    function automatic logic [dsbrm_pkg::TIME_W-1:0] sat_add(
        logic [dsbrm_pkg::TIME_W-1:0] t, logic [dsbrm_pkg::TIME_W-1:0] d);
        logic [dsbrm_pkg::TIME_W:0] sum;
        sum = {1'b0, t} + {1'b0, d};
        return sum[dsbrm_pkg::TIME_W] ? dsbrm_pkg::TIME_MAX : sum[dsbrm_pkg::TIME_W-1:0];
    endfunction

    function automatic bit set_all_banks(logic [dsbrm_pkg::MASK_W-1:0] m, int s);
        for (int g = 0; g < GROUPS_PER_RANK; g++)
            if (g * BANKS_PER_GROUP + s >= dsbrm_pkg::MASK_W || !m[g * BANKS_PER_GROUP + s])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit set_any_bank(logic [dsbrm_pkg::MASK_W-1:0] m, int s);
        for (int g = 0; g < GROUPS_PER_RANK; g++)
            if (g * BANKS_PER_GROUP + s < dsbrm_pkg::MASK_W && m[g * BANKS_PER_GROUP + s])
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic int lowest_remaining();
        for (int s = 0; s < BANKS_PER_GROUP; s++)
            if (remaining[s])
                return s;
        return 0;
    endfunction

    function automatic bit pick_idle_set(logic [dsbrm_pkg::MASK_W-1:0] idle);
        cur_set = lowest_remaining();
        for (int s = 0; s < BANKS_PER_GROUP; s++) begin
            if (remaining[s] && set_all_banks(idle, s)) begin
                cur_set = s;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [1:0] open_or(logic [dsbrm_pkg::MASK_W-1:0] act, logic [1:0] cmd);
        return set_any_bank(act, cur_set) ? dsbrm_pkg::CMD_PRESB : cmd;
    endfunction

    function automatic logic [1:0] evaluate_tick(dsbrm_pkg::item_t it, output bit blk,
                                                 output bit irq);
        logic [63:0] wide_now;
        logic [63:0] reach;
        bit          forced;
        bit          busy;
        bit          found;
        logic [1:0]  cmd;
        blk = 1'b0;
        irq = 1'b0;
        wide_now = 64'(it.now);
        reach = 64'(trig_time);
        reach = reach + 64'(cfg_interval);
        if (it.now >= trig_time) begin
            irq = 1'b1;
            if (sleeping)
                return dsbrm_pkg::CMD_NOP;
            if (wide_now >= reach) begin
                trig_time = sat_add(trig_time, 48'(cfg_interval));
                pulled_in = 1'b0;
            end
            if (!pulled_in) begin
                forced = (flex == cfg_max_post);
                busy = 1'b1;
                if (!skip_sel)
                    busy = !pick_idle_set(it.idle_mask);
                if (busy && !forced) begin
                    if (flex < 127)
                        flex = flex + 1;
                    trig_time = sat_add(trig_time, 48'(cfg_interval));
                end else begin
                    cmd = open_or(it.activated_mask, dsbrm_pkg::CMD_REFSB);
                    if (cmd == dsbrm_pkg::CMD_REFSB && forced) begin
                        blk = 1'b1;
                        skip_sel = 1'b1;
                    end
                    return cmd;
                end
            end else begin
                if (!pick_idle_set(it.idle_mask)) begin
                    pulled_in = 1'b0;
                    trig_time = sat_add(trig_time, 48'(cfg_interval));
                end else begin
                    return open_or(it.activated_mask, dsbrm_pkg::CMD_REFSB);
                end
            end
        end
        if (cfg_rfm) begin
            found = 1'b0;
            for (int s = 0; s < BANKS_PER_GROUP; s++) begin
                if (set_any_bank(it.mmt_mask, s)) begin
                    found = 1'b1;
                    cur_set = s;
                end
            end
            if (found) begin
                blk = 1'b1;
                return open_or(it.activated_mask, dsbrm_pkg::CMD_RFMSB);
            end
            for (int s = 0; s < BANKS_PER_GROUP; s++) begin
                if (set_any_bank(it.imt_mask, s) && set_all_banks(it.idle_mask, s)) begin
                    cur_set = s;
                    return open_or(it.activated_mask, dsbrm_pkg::CMD_RFMSB);
                end
            end
        end
        return dsbrm_pkg::CMD_NOP;
    endfunction

    function automatic void apply_report(dsbrm_pkg::item_t it);
        case (it.issued_command)
            dsbrm_pkg::ISSUE_REFSB: begin
                skip_sel = 1'b0;
                remaining[cur_set] = 1'b0;
                if (remaining == '0)
                    remaining = ALL_SETS;
                cur_set = lowest_remaining();
                if (pulled_in) begin
                    if (flex > -128)
                        flex = flex - 1;
                end else begin
                    pulled_in = 1'b1;
                end
                if (flex == -cfg_max_pull) begin
                    pulled_in = 1'b0;
                    trig_time = sat_add(trig_time, 48'(cfg_interval));
                end
            end
            dsbrm_pkg::ISSUE_REFAB: begin
                pulled_in = 1'b0;
                trig_time = sat_add(it.now, 48'(cfg_interval));
                sleeping = 1'b0;
                remaining = ALL_SETS;
                cur_set = 0;
                skip_sel = 1'b0;
            end
            dsbrm_pkg::ISSUE_PDE: sleeping = 1'b1;
            dsbrm_pkg::ISSUE_SRE: begin
                sleeping = 1'b1;
                trig_time = dsbrm_pkg::TIME_MAX;
            end
            dsbrm_pkg::ISSUE_PDX: sleeping = 1'b0;
            default: ;
        endcase
    endfunction

    function automatic dsbrm_pkg::result_t decide_refresh(dsbrm_pkg::item_t it);
        dsbrm_pkg::result_t r;
        bit                 blk;
        bit                 irq;
        logic [1:0]         cmd;
        blk = 1'b0;
        irq = 1'b0;
        cmd = dsbrm_pkg::CMD_NOP;
        if (it.func == dsbrm_pkg::FUNC_TICK)
            cmd = evaluate_tick(it, blk, irq);
        else
            apply_report(it);
        r.next_command  = cmd;
        r.target_set    = cur_set[1:0];
        r.block_request = blk;
        r.pdm_interrupt = irq;
        r.next_trigger  = trig_time;
        return r;
    endfunction

    function automatic logic [dsbrm_pkg::MASK_W-1:0] bank_mask(int ones_pct, int set_pct,
                                                               int zero_pct);
        int          r;
        logic [3:0]  nib;
        logic [31:0] m;
        r = $urandom_range(0, 99);
        nib = 4'($urandom_range(0, 15));
        m = {8{nib}};
        if (r < ones_pct)
            return '1;
        if (r < ones_pct + set_pct) begin
            if ($urandom_range(0, 1))
                m = m ^ (32'h1 << $urandom_range(0, 31));
            return m;
        end
        if (r < ones_pct + set_pct + zero_pct)
            return '0;
        return $urandom;
    endfunction

    function automatic logic [dsbrm_pkg::MASK_W-1:0] threshold_mask();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return '0;
        if (r < 95)
            return 32'h1 << $urandom_range(0, 31);
        return $urandom;
    endfunction

    function automatic dsbrm_pkg::item_t random_item();
        dsbrm_pkg::item_t it;
        int               r;
        int               q;
        logic [63:0]      wide;
        r = $urandom_range(0, 99);
        q = $urandom_range(0, 99);
        it.idle_mask      = bank_mask(40, 35, 10);
        it.activated_mask = bank_mask(5, 20, 60);
        it.mmt_mask       = threshold_mask();
        it.imt_mask       = threshold_mask();
        it.func           = dsbrm_pkg::FUNC_REPORT;
        it.issued_command = 3'($urandom_range(5, 7));
        if (r < 58) begin
            it.func = dsbrm_pkg::FUNC_TICK;
            it.issued_command = 3'($urandom_range(0, 7));
            if (q < 50)
                base_now = base_now + 48'($urandom_range(0, phase_interval));
            else if (q < 80)
                base_now = base_now + 48'($urandom_range(0, 3));
            else if (q < 95)
                base_now = base_now + 48'(phase_interval)
                           + 48'($urandom_range(0, phase_interval));
            else
                base_now = base_now + 48'(3 * phase_interval);
        end else if (r < 82) begin
            it.issued_command = dsbrm_pkg::ISSUE_REFSB;
        end else if (r < 87) begin
            it.issued_command = dsbrm_pkg::ISSUE_REFAB;
        end else if (r < 90) begin
            it.issued_command = dsbrm_pkg::ISSUE_PDE;
        end else if (r < 93) begin
            it.issued_command = dsbrm_pkg::ISSUE_PDX;
        end else if (r < 95) begin
            it.issued_command = dsbrm_pkg::ISSUE_SRE;
        end
        it.now = base_now;
        if ($urandom_range(0, 99) < 4) begin
            wide = {$urandom, $urandom};
            it.now = wide[dsbrm_pkg::TIME_W-1:0];
        end
        return it;
    endfunction

    function automatic dsbrm_pkg::item_t make_item(logic func, logic [dsbrm_pkg::TIME_W-1:0] now,
                                                   logic [2:0] cmd,
                                                   logic [31:0] idle, logic [31:0] act,
                                                   logic [31:0] mmt, logic [31:0] imt);
        dsbrm_pkg::item_t it;
        it.func           = func;
        it.now            = now;
        it.issued_command = cmd;
        it.idle_mask      = idle;
        it.activated_mask = act;
        it.mmt_mask       = mmt;
        it.imt_mask       = imt;
        return it;
    endfunction

    task automatic note_mismatch(string what, logic [dsbrm_pkg::TIME_W-1:0] want,
                                 logic [dsbrm_pkg::TIME_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(decide_refresh(pending_items[0]));
                pending_items.pop_front();
            end
            if (s_valid && !s_ready) begin
                // hold the beat
            end else if (pending_items.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                s_func           <= pending_items[0].func;
                s_now            <= pending_items[0].now;
                s_issued_command <= pending_items[0].issued_command;
                s_idle_mask      <= pending_items[0].idle_mask;
                s_activated_mask <= pending_items[0].activated_mask;
                s_mmt_mask       <= pending_items[0].mmt_mask;
                s_imt_mask       <= pending_items[0].imt_mask;
                s_valid          <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge aclk) begin : result_check
        dsbrm_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected result beat", '0, m_next_trigger);
                end else begin
                    want = expected_results.pop_front();
                    if (m_next_command !== want.next_command)
                        note_mismatch("next_command", 48'(want.next_command),
                                      48'(m_next_command));
                    if (m_target_set !== want.target_set)
                        note_mismatch("target_set", 48'(want.target_set), 48'(m_target_set));
                    if (m_block_request !== want.block_request)
                        note_mismatch("block_request", 48'(want.block_request),
                                      48'(m_block_request));
                    if (m_pdm_interrupt !== want.pdm_interrupt)
                        note_mismatch("pdm_interrupt", 48'(want.pdm_interrupt),
                                      48'(m_pdm_interrupt));
                    if (m_next_trigger !== want.next_trigger)
                        note_mismatch("next_trigger", want.next_trigger, m_next_trigger);
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_items.size() != 0 || expected_results.size() != 0 || s_valid);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(logic [dsbrm_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            dsbrm_pkg::CFG_REFRESH_INTERVAL: cfg_interval = val[15:0];
            dsbrm_pkg::CFG_FIRST_TRIGGER:    trig_time = {16'b0, val};
            dsbrm_pkg::CFG_MAX_POSTPONED:    cfg_max_post = int'(val[6:0]);
            dsbrm_pkg::CFG_MAX_PULLED_IN:    cfg_max_pull = int'(val[6:0]);
            dsbrm_pkg::CFG_RFM_ENABLE:       cfg_rfm = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] interval, logic [31:0] first, logic [31:0] post,
                             logic [31:0] pull, logic [31:0] rfm);
        write_register(dsbrm_pkg::CFG_REFRESH_INTERVAL, interval);
        write_register(dsbrm_pkg::CFG_FIRST_TRIGGER, first);
        write_register(dsbrm_pkg::CFG_MAX_POSTPONED, post);
        write_register(dsbrm_pkg::CFG_MAX_PULLED_IN, pull);
        write_register(dsbrm_pkg::CFG_RFM_ENABLE, rfm);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        phase_interval = interval[15:0];
    endtask

    task automatic run_directed();
        logic [31:0] ones;
        ones = '1;
        configure(4, 10, 2, 2, 1);
        @(negedge aclk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_TICK, 0, 3'd0, 0, 0, 0, 0));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_TICK, 0, 3'd0, ones, 0,
                                          32'h208, 0));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_TICK, 0, 3'd0, ones,
                                          32'h4000_0000, 32'h40, 0));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_TICK, 0, 3'd0, ones, 0, 0,
                                          32'h20));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_TICK, 0, 3'd0, 32'hFFFF_FFDF, 0,
                                          0, 32'h20));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_TICK, 10, 3'd0, ones, 0, 0, 0));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_REPORT, 10, dsbrm_pkg::ISSUE_REFSB,
                                          0, 0, 0, 0));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_TICK, 11, 3'd0, ones,
                                          SET0_BANKS << 1, 0, 0));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_REPORT, 11, dsbrm_pkg::ISSUE_REFSB,
                                          0, 0, 0, 0));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_REPORT, 11, dsbrm_pkg::ISSUE_REFSB,
                                          0, 0, 0, 0));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_TICK, 14, 3'd0, 0, 0, 0, 0));
        repeat (5)
            pending_items.push_back(make_item(dsbrm_pkg::FUNC_TICK, 100, 3'd0, 0, 0, 0, 0));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_TICK, 100, 3'd0, ones, SET0_BANKS,
                                          0, 0));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_REPORT, 100,
                                          dsbrm_pkg::ISSUE_REFSB, 0, 0, 0, 0));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_REPORT, dsbrm_pkg::TIME_MAX,
                                          dsbrm_pkg::ISSUE_REFAB, 0, 0, 0, 0));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_TICK, dsbrm_pkg::TIME_MAX, 3'd7,
                                          ones, ones, ones, ones));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_REPORT, dsbrm_pkg::TIME_MAX,
                                          dsbrm_pkg::ISSUE_PDE, 0, 0, 0, 0));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_TICK, dsbrm_pkg::TIME_MAX, 3'd0,
                                          ones, 0, 0, 0));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_REPORT, 0, dsbrm_pkg::ISSUE_PDX,
                                          0, 0, 0, 0));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_REPORT, 0, dsbrm_pkg::ISSUE_SRE,
                                          0, 0, 0, 0));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_REPORT, 0, 3'd7, ones, ones, ones,
                                          ones));
        pending_items.push_back(make_item(dsbrm_pkg::FUNC_REPORT, 200,
                                          dsbrm_pkg::ISSUE_REFAB, 0, 0, 0, 0));
        wait_drained();
    endtask

    task automatic run_phase(logic [31:0] interval, logic [31:0] first, logic [31:0] post,
                             logic [31:0] pull, logic [31:0] rfm, int count,
                             int idle_pct, int stall_pct, bit hold_midway);
        configure(interval, first, post, pull, rfm);
        @(negedge aclk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        base_now = (first == 32'hFFFF_FFFF) ? '0 : ((first > 8) ? 48'(first - 8) : '0);
        for (int i = 0; i < count; i++) begin
            // let every result come back before the second half
            if (hold_midway && i == count / 2)
                wait_drained();
            pending_items.push_back(random_item());
        end
        wait_drained();
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        run_phase(16, 20, 32, 32, 1, 212, 0, 0, 1'b0);
        run_phase(1, 0, 0, 0, 0, 212, 74, 0, 1'b0);
        run_phase(65535, 32'hFFFF_FFFF, 64, 64, 1, 212, 0, 74, 1'b0);
        run_phase(7, 100, 3, 64, 1, 212, 29, 29, 1'b1);
        run_phase(3, 5, 64, 0, 0, 212, 0, 0, 1'b0);
        run_phase($urandom_range(1, 200), $urandom_range(0, 5000), $urandom_range(0, 64),
                  $urandom_range(0, 64), $urandom_range(0, 1), 212, 74, 0, 1'b0);
        run_phase(50, 1000, 1, 2, 1, 212, 0, 74, 1'b0);
        run_phase($urandom_range(1, 200), $urandom_range(0, 5000), $urandom_range(0, 64),
                  $urandom_range(0, 64), $urandom_range(0, 1), 212, 29, 29, 1'b0);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
